@@ src/fpm_pkg.sv @@
// Shared types and constants for the failureless multi-pattern matcher.
// No dependencies.
`default_nettype none
package fpm_pkg;
   localparam int NUM_NODES_DEF = 1024;
   localparam int MAX_LEN_DEF   = 32;
   localparam int NODE_W        = 10;
   localparam int SYM_W         = 8;
   localparam int OFS_W         = 32;
   localparam int NODE_LIMIT    = 1024;

   localparam logic OP_EDGE = 1'b0;
   localparam logic OP_TEXT = 1'b1;

   typedef struct packed {
      logic              alive;
      logic [NODE_W-1:0] node;
      logic [NODE_W-1:0] best;
      logic [OFS_W-1:0]  start;
   } thread_type;

   typedef struct packed {
      logic              present;
      logic [NODE_W-1:0] target;
   } edge_type;

   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctrl_type;
endpackage
`default_nettype wire

@@ src/fpm_cell.sv @@
// One thread cell of the ring: loads a new thread or takes its neighbor's.
// Depends on fpm_pkg.
`default_nettype none
module fpm_cell (
   input  wire                  clock,
   input  wire                  reset,
   input  fpm_pkg::cell_ctrl_type ctrl,
   input  fpm_pkg::thread_type  new_thread,
   input  fpm_pkg::thread_type  next_thread,
   output fpm_pkg::thread_type  thread
);
   import fpm_pkg::*;

   thread_type thread_ff, thread_in;

   always_comb begin
      thread_in = thread_ff;
      if (ctrl.load) begin
         thread_in = new_thread;
      end else if (ctrl.shift) begin
         thread_in = next_thread;
      end
   end

   always_ff @(posedge clock) begin
      thread_ff <= thread_in;
      if (reset) begin
         thread_ff.alive <= 1'b0;
      end
   end

   assign thread = thread_ff;
endmodule
`default_nettype wire

@@ src/fpm_step.sv @@
// Advance stage: holds the thread whose edge lookup is in flight, applies the edge.
// Depends on fpm_pkg.
`default_nettype none
module fpm_step #(
   parameter int STORE_NODES = fpm_pkg::NODE_LIMIT
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           take,
   input  fpm_pkg::thread_type           in_thread,
   input  fpm_pkg::edge_type             edge_rd,
   input  wire [fpm_pkg::NODE_W-1:0]     pattern_count,
   output fpm_pkg::thread_type           out_thread
);
   import fpm_pkg::*;

   thread_type hold_ff, hold_in;

   always_comb begin
      hold_in = take ? in_thread : hold_ff;
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
      if (reset) begin
         hold_ff.alive <= 1'b0;
      end
   end

   always_comb begin
      out_thread = hold_ff;
      if (hold_ff.alive) begin
         if (!edge_rd.present || (32'(edge_rd.target) >= STORE_NODES)) begin
            out_thread.alive = 1'b0;
         end else begin
            out_thread.node = edge_rd.target;
            if (edge_rd.target < pattern_count) begin
               out_thread.best = edge_rd.target + NODE_W'(1);
            end
         end
      end
   end
endmodule
`default_nettype wire

@@ src/fpm_edge_store.sv @@
// Edge store memory with its clearing sweep after reset; registered read.
// Depends on fpm_pkg.
`default_nettype none
module fpm_edge_store #(
   parameter int STORE_NODES = fpm_pkg::NODE_LIMIT
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        wr_en,
   input  wire [fpm_pkg::NODE_W-1:0]  wr_node,
   input  wire [fpm_pkg::SYM_W-1:0]   wr_sym,
   input  fpm_pkg::edge_type          wr_edge,
   input  wire [fpm_pkg::NODE_W-1:0]  rd_node,
   input  wire [fpm_pkg::SYM_W-1:0]   rd_sym,
   output fpm_pkg::edge_type          rd_edge,
   output logic                       busy
);
   import fpm_pkg::*;

   localparam int NW    = (STORE_NODES > 1) ? $clog2(STORE_NODES) : 1;
   localparam int AW    = NW + SYM_W;
   localparam int DEPTH = STORE_NODES * 256;

   edge_type       mem [DEPTH];
   edge_type       rd_ff;
   logic           clearing_ff, clearing_in;
   logic [AW-1:0]  clr_addr_ff, clr_addr_in;
   logic           wr_ok;
   logic [AW-1:0]  wr_addr, rd_addr;

   assign wr_ok   = wr_en && (32'(wr_node) < STORE_NODES);
   assign wr_addr = {wr_node[NW-1:0], wr_sym};
   assign rd_addr = {rd_node[NW-1:0], rd_sym};

   always_comb begin
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + AW'(1);
         if (clr_addr_ff == AW'(DEPTH - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (wr_ok) begin
         mem[wr_addr] <= wr_edge;
      end
      rd_ff <= mem[rd_addr];
   end

   assign rd_edge = rd_ff;
   assign busy    = clearing_ff;
endmodule
`default_nettype wire

@@ src/failureless_multi_pattern_matcher.sv @@
// Failureless multi-pattern matcher: ring of thread cells, one shared edge lookup.
// Text word: accepted, then advanced (one edge-store read per cell), then, on text_last
// or a full ring, one result emitted per cycle unless the response stalls. Edge write
// word: written when accepted. Reset starts a clearing sweep of the edge store over
// min(NUM_NODES,1024)*256 entries (262144 by default); no word is accepted meanwhile.
// Depends on fpm_pkg, fpm_cell, fpm_step, fpm_edge_store.
`default_nettype none
module failureless_multi_pattern_matcher #(
   parameter int NUM_NODES       = fpm_pkg::NUM_NODES_DEF,
   parameter int MAX_PATTERN_LEN = fpm_pkg::MAX_LEN_DEF
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // [9:0] entry_node, [17:10] entry_symbol, [27:18] entry_target,
   // [28] entry_present, [36:29] text_byte, [39:37] zero
   input  wire  [39:0] req_tdata,
   input  wire         req_tuser,   // [0] opcode
   input  wire         req_tlast,   // text_last
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // [31:0] start_offset, [41:32] match_id, [47:42] zero
   output logic [47:0] rsp_tdata,
   output logic        rsp_tlast,   // last
   input  wire         csr_wr_en,
   input  wire  [9:0]  csr_wr_data  // pattern_count
);
   import fpm_pkg::*;

   localparam int P           = MAX_PATTERN_LEN;
   localparam int STORE_NODES = (NUM_NODES < NODE_LIMIT) ? NUM_NODES : NODE_LIMIT;
   localparam int CW          = $clog2(P + 1);

   typedef enum logic [1:0] {ST_IDLE, ST_ADV, ST_EMIT} state_type;

   state_type          state_ff;
   logic [CW-1:0]      step_ff, count_ff, left_ff;
   logic               last_ff;
   logic [SYM_W-1:0]   byte_ff;
   logic [OFS_W-1:0]   pos_ff;
   logic [NODE_W-1:0]  pcount_ff;
   logic               rsp_valid_ff, rsp_last_ff;
   logic [OFS_W-1:0]   rsp_start_ff;
   logic [NODE_W-1:0]  rsp_id_ff;

   logic               busy, accept, text_acc, edge_acc, adv_step, emit_fire;
   thread_type         cells [P];
   thread_type         step_out, new_thread, empty_thread;
   edge_type           wr_edge, rd_edge;

   assign req_tready = (state_ff == ST_IDLE) && !busy;
   assign accept     = req_tvalid && req_tready;
   assign text_acc   = accept && (req_tuser == OP_TEXT);
   assign edge_acc   = accept && (req_tuser == OP_EDGE);
   assign adv_step   = (state_ff == ST_ADV);
   assign emit_fire  = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_tready);

   assign wr_edge.present = req_tdata[28];
   assign wr_edge.target  = req_tdata[27:18];

   assign new_thread.alive = 32'(pcount_ff) < STORE_NODES;
   assign new_thread.node  = pcount_ff;
   assign new_thread.best  = '0;
   assign new_thread.start = pos_ff;
   assign empty_thread     = '0;

   fpm_edge_store #(.STORE_NODES(STORE_NODES)) u_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (edge_acc),
      .wr_node (req_tdata[9:0]),
      .wr_sym  (req_tdata[17:10]),
      .wr_edge (wr_edge),
      .rd_node (cells[0].node),
      .rd_sym  (byte_ff),
      .rd_edge (rd_edge),
      .busy    (busy)
   );

   fpm_step #(.STORE_NODES(STORE_NODES)) u_step (
      .clock         (clock),
      .reset         (reset),
      .take          (adv_step),
      .in_thread     (cells[0]),
      .edge_rd       (rd_edge),
      .pattern_count (pcount_ff),
      .out_thread    (step_out)
   );

   for (genvar i = 0; i < P; i++) begin : g_cell
      cell_ctrl_type ctrl;
      thread_type    next_thread;
      assign ctrl.load  = text_acc && (count_ff == CW'(i));
      assign ctrl.shift = adv_step || emit_fire;
      if (i < P - 1) begin : g_mid
         assign next_thread = cells[i+1];
      end else begin : g_end
         assign next_thread = adv_step ? step_out : empty_thread;
      end
      fpm_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .new_thread  (new_thread),
         .next_thread (next_thread),
         .thread      (cells[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         count_ff     <= '0;
         left_ff      <= '0;
         last_ff      <= 1'b0;
         pos_ff       <= '0;
         pcount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            pcount_ff <= csr_wr_data;
         end
         if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (text_acc) begin
                  byte_ff  <= req_tdata[36:29];
                  last_ff  <= req_tlast;
                  count_ff <= count_ff + CW'(1);
                  pos_ff   <= req_tlast ? '0 : pos_ff + OFS_W'(1);
                  step_ff  <= '0;
                  state_ff <= ST_ADV;
               end
            end
            ST_ADV: begin
               step_ff <= step_ff + CW'(1);
               if (step_ff == CW'(P)) begin
                  if (last_ff) begin
                     left_ff  <= count_ff;
                     state_ff <= ST_EMIT;
                  end else if (count_ff == CW'(P)) begin
                     left_ff  <= CW'(1);
                     state_ff <= ST_EMIT;
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            ST_EMIT: begin
               if (emit_fire) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_start_ff <= cells[0].start;
                  rsp_id_ff    <= cells[0].best;
                  rsp_last_ff  <= (left_ff == CW'(1));
                  left_ff      <= left_ff - CW'(1);
                  count_ff     <= count_ff - CW'(1);
                  if (left_ff == CW'(1)) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_id_ff, rsp_start_ff};
   assign rsp_tlast  = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(P)) else $error("thread count above ring size");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !req_tready) else $error("word accepted during clear sweep");
   a_emit_left: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (left_ff != '0) && (left_ff <= count_ff))
      else $error("emit count out of range");
endmodule
`default_nettype wire

@@ verif/fpm_checker.sv @@
// Scoreboard for the failureless multi-pattern matcher: mirrors edge store, threads
// and pattern count from the observed words, predicts results and compares them.
// Depends on fpm_pkg.
`default_nettype none
module fpm_checker (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_tvalid,
   input  wire                req_tready,
   input  wire         [39:0] req_tdata,
   input  wire                req_tuser,
   input  wire                req_tlast,
   input  wire                rsp_tvalid,
   input  wire                rsp_tready,
   input  wire         [47:0] rsp_tdata,
   input  wire                rsp_tlast,
   input  wire                csr_wr_en,
   input  wire         [9:0]  csr_wr_data,
   output int                 fail_count,
   output int                 pending
);
   import fpm_pkg::*;

   localparam int RING = MAX_LEN_DEF;

   typedef struct packed {
      logic [OFS_W-1:0]  start;
      logic [NODE_W-1:0] id;
      logic              last;
   } match_rec_type;

   edge_type          edges [NODE_LIMIT*256];
   logic [NODE_W-1:0] pat_count;
   thread_type        threads [RING];
   int                ring_head, ring_count;
   logic [OFS_W-1:0]  text_pos;
   match_rec_type     match_q [$];

   task automatic scan_byte(input logic [SYM_W-1:0] b, input logic fin);
      int            slot;
      edge_type      e;
      match_rec_type r;
      slot = (ring_head + ring_count) % RING;
      threads[slot].node  = pat_count;
      threads[slot].alive = 1'b1;
      threads[slot].best  = '0;
      threads[slot].start = text_pos;
      ring_count++;
      for (int i = 0; i < ring_count; i++) begin
         slot = (ring_head + i) % RING;
         if (threads[slot].alive) begin
            e = edges[int'(threads[slot].node) * 256 + int'(b)];
            if (!e.present) begin
               threads[slot].alive = 1'b0;
            end else begin
               threads[slot].node = e.target;
               if (e.target < pat_count) threads[slot].best = e.target + NODE_W'(1);
            end
         end
      end
      if (fin) begin
         for (int i = 0; i < ring_count; i++) begin
            slot = (ring_head + i) % RING;
            r.start = threads[slot].start;
            r.id    = threads[slot].best;
            r.last  = (i + 1 == ring_count);
            match_q.push_back(r);
            threads[slot].alive = 1'b0;
         end
         ring_head  = 0;
         ring_count = 0;
         text_pos   = '0;
      end else begin
         if (ring_count >= RING) begin
            r.start = threads[ring_head].start;
            r.id    = threads[ring_head].best;
            r.last  = 1'b1;
            match_q.push_back(r);
            threads[ring_head].alive = 1'b0;
            ring_head = (ring_head + 1) % RING;
            ring_count--;
         end
         text_pos++;
      end
   endtask

   always @(posedge clock) begin
      match_rec_type exp_r;
      match_rec_type got;
      edge_type      ne;
      if (reset) begin
         foreach (edges[i]) edges[i] = '0;
         foreach (threads[i]) threads[i] = '0;
         pat_count  = '0;
         ring_head  = 0;
         ring_count = 0;
         text_pos   = '0;
         match_q.delete();
         fail_count = 0;
      end else begin
         if (csr_wr_en) pat_count = csr_wr_data;
         if (req_tvalid && req_tready) begin
            if (req_tuser == OP_EDGE) begin
               ne.present = req_tdata[28];
               ne.target  = req_tdata[28] ? req_tdata[27:18] : '0;
               edges[int'(req_tdata[9:0]) * 256 + int'(req_tdata[17:10])] = ne;
            end else begin
               scan_byte(req_tdata[36:29], req_tlast);
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got.start = rsp_tdata[31:0];
            got.id    = rsp_tdata[41:32];
            got.last  = rsp_tlast;
            if (match_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected word: start %0d id %0d last %0b",
                           got.start, got.id, got.last);
            end else begin
               exp_r = match_q.pop_front();
               if (got !== exp_r || rsp_tdata[47:42] !== 6'b0) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: exp start %0d id %0d last %0b, got %0d %0d %0b",
                              exp_r.start, exp_r.id, exp_r.last,
                              got.start, got.id, got.last);
               end
            end
         end
      end
      pending = match_q.size();
   end
endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
// Top of the matcher testbench: clock, reset, edge/text stimulus, response pacing
// and verdict. Depends on fpm_pkg, fpm_checker and failureless_multi_pattern_matcher.
`default_nettype none
module tb_top;
   import fpm_pkg::*;

   localparam int IDLE_LIMIT = 1000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_wr_en = 1'b0;
   logic [9:0]  csr_wr_data = '0;
   int          fail_count, pending;
   int          idle_cycles = 0;
   int          rsp_gap = 0;
   int          words_sent = 0;
   logic        calm = 1'b0;
   logic        hold_on = 1'b0;

   always #1 clock = ~clock;

   failureless_multi_pattern_matcher dut (.*);

   fpm_checker chk (.*);

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) rsp_gap <= calm ? 0 : $urandom_range(0, 10);
      else if (rsp_gap > 0) rsp_gap <= rsp_gap - 1;
   end

   always @(negedge clock) rsp_tready <= !reset && rsp_gap == 0 && !hold_on;

   initial begin
      wait (words_sent >= 7);
      @(negedge clock);
      hold_on = 1'b1;
      repeat (400) @(negedge clock);
      hold_on = 1'b0;
   end

   task automatic send_word(input logic op, input logic [36:0] body, input logic fin);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         @(negedge clock) req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {3'b0, body};
      req_tlast  <= fin;
      do @(posedge clock); while (!req_tready);
      words_sent++;
   endtask

   task automatic put_edge(input logic [9:0] node, input logic [7:0] sym,
                           input logic [9:0] tgt, input logic present);
      send_word(OP_EDGE, {8'($urandom), present, tgt, sym, node}, 1'($urandom));
   endtask

   task automatic put_text(input logic [7:0] b, input logic fin);
      send_word(OP_TEXT, {b, 29'($urandom)}, fin);
   endtask

   task automatic drain_and_set(input logic [9:0] count);
      @(negedge clock) req_tvalid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= count;
      @(negedge clock) csr_wr_en <= 1'b0;
   endtask

   initial begin
      logic [9:0] pool [6];
      logic [7:0] alpha [4];
      logic [9:0] pc;
      int         len, text_words, phase;
      repeat (12) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // directed: patterns "a" (node 0) and "abc" (node 1), root 3
      drain_and_set(10'd3);
      put_edge(10'd3, 8'h61, 10'd0, 1'b1);
      put_edge(10'd0, 8'h62, 10'd4, 1'b1);
      put_edge(10'd4, 8'h63, 10'd1, 1'b1);
      put_edge(10'd1023, 8'hff, 10'd1023, 1'b1);
      put_edge(10'd0, 8'h00, 10'd1023, 1'b0);
      put_text(8'h61, 1'b0);
      put_text(8'h62, 1'b0);
      put_text(8'h63, 1'b1);
      put_text(8'h61, 1'b1);
      put_edge(10'd4, 8'h63, 10'd0, 1'b0);
      put_text(8'h61, 1'b0);
      put_text(8'h62, 1'b0);
      put_text(8'h63, 1'b1);
      for (int i = 0; i < 34; i++) put_text(8'h61, 1'b0);
      put_text(8'h00, 1'b1);
      put_text(8'hff, 1'b1);

      text_words = 0;
      phase = 0;
      while (text_words < 120) begin
         case (phase)
            0:       pc = 10'd0;
            1:       pc = 10'd1023;
            2:       pc = 10'd1;
            default: pc = 10'($urandom_range(0, 1023));
         endcase
         drain_and_set(pc);
         calm = (phase % 3 == 2);
         pool[0] = pc;
         for (int i = 1; i < 6; i++)
            pool[i] = ($urandom_range(0, 1) || pc == 0) ? 10'($urandom)
                                                       : 10'($urandom_range(0, pc - 1));
         foreach (alpha[i]) alpha[i] = 8'($urandom);
         for (int i = 0; i < 14; i++) begin
            if ($urandom_range(0, 9) == 0)
               put_edge(10'($urandom), 8'($urandom), 10'($urandom), 1'($urandom));
            else
               put_edge(pool[$urandom_range(0, 5)], alpha[$urandom_range(0, 3)],
                        pool[$urandom_range(0, 5)], $urandom_range(0, 4) != 0);
         end
         for (int t = 0; t < 2; t++) begin
            len = $urandom_range(1, 45);
            for (int k = 0; k < len; k++) begin
               if ($urandom_range(0, 19) == 0)
                  put_edge(pool[$urandom_range(0, 5)], alpha[$urandom_range(0, 3)],
                           pool[$urandom_range(0, 5)], 1'($urandom));
               put_text(($urandom_range(0, 4) != 0) ? alpha[$urandom_range(0, 3)]
                                                    : 8'($urandom), k == len - 1);
               text_words++;
            end
         end
         phase++;
      end
      calm = 1'b0;
      @(negedge clock) req_tvalid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
`default_nettype wire
